/* rtl/signed_vector_angle_about_axis_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vector angle block
// Shared wrappers for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SIGNED_VECTOR_ANGLE_ABOUT_AXIS_TOP_ASSERT_SVH
`define SIGNED_VECTOR_ANGLE_ABOUT_AXIS_TOP_ASSERT_SVH

// Same-cycle implication.
`define SVAA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SVAA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/svaa_pkg.sv */
// ----------------------------------------------------------------------------
// svaa_pkg
// Request and result types, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package svaa_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 24;
    localparam int ATAN_TAB_LEN          = 32;

    localparam logic [15:0] COS_TOL_RESET = 16'd1074;
    localparam logic [31:0] ONE_Q30       = 32'h4000_0000;

    // Angles in units of 2^-24 degrees.
    localparam logic [32:0] DEG90  = 33'd1509949440;
    localparam logic [32:0] DEG180 = 33'd3019898880;
    localparam logic [32:0] DEG360 = 33'd6039797760;

    // Full turn in the Q9.16 output format.
    localparam logic [25:0] OUT_DEG360 = 26'd23592960;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } t_req;

    typedef struct packed {
        logic [24:0] angle_deg;
        logic        status;
    } t_rsp;

    // atan(2^-i) in units of 2^-24 degrees.
    function automatic logic [30:0] atan_deg(input int idx);
        logic [30:0] v;
        case (idx)
            0:  v = 31'd754974720;
            1:  v = 31'd445687602;
            2:  v = 31'd235489088;
            3:  v = 31'd119537938;
            4:  v = 31'd60000934;
            5:  v = 31'd30029717;
            6:  v = 31'd15018523;
            7:  v = 31'd7509720;
            8:  v = 31'd3754917;
            9:  v = 31'd1877466;
            10: v = 31'd938734;
            11: v = 31'd469367;
            12: v = 31'd234684;
            13: v = 31'd117342;
            14: v = 31'd58671;
            15: v = 31'd29335;
            16: v = 31'd14668;
            17: v = 31'd7334;
            18: v = 31'd3667;
            19: v = 31'd1833;
            20: v = 31'd917;
            21: v = 31'd458;
            22: v = 31'd229;
            23: v = 31'd115;
            24: v = 31'd57;
            25: v = 31'd29;
            26: v = 31'd14;
            27: v = 31'd7;
            28: v = 31'd4;
            29: v = 31'd2;
            30: v = 31'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/svaa_sqrt.sv */
// ----------------------------------------------------------------------------
// svaa_sqrt
// Pipelined integer square root, one result bit per stage, several lanes
// in parallel, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module svaa_sqrt #(
    parameter int LANES  = 1,
    parameter int OUT_W  = 32,
    parameter int SIDE_W = 1,
    localparam int IN_W  = 2 * OUT_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [LANES-1:0][IN_W-1:0]        i_val,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [LANES-1:0][OUT_W-1:0]       o_root,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int REM_W = OUT_W + 1;

    logic [LANES-1:0][IN_W-1:0]  r_src  [OUT_W];
    logic [LANES-1:0][REM_W-1:0] r_rem  [OUT_W+1];
    logic [LANES-1:0][OUT_W-1:0] r_root [OUT_W+1];
    logic [SIDE_W-1:0]           r_side [OUT_W+1];
    logic                        r_vld  [OUT_W+1];

    logic [LANES-1:0][REM_W-1:0] n_rem  [1:OUT_W];
    logic [LANES-1:0][OUT_W-1:0] n_root [1:OUT_W];

    always_comb begin
        logic [REM_W+1:0] sh;
        logic [REM_W+1:0] trial;
        for (int k = 0; k < OUT_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                sh    = {r_rem[k][l], r_src[k][l][IN_W-1 -: 2]};
                trial = {1'b0, r_root[k][l], 2'b01};
                if (sh >= trial) begin
                    n_rem[k+1][l]  = REM_W'(sh - trial);
                    n_root[k+1][l] = {r_root[k][l][OUT_W-2:0], 1'b1};
                end else begin
                    n_rem[k+1][l]  = REM_W'(sh);
                    n_root[k+1][l] = {r_root[k][l][OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= OUT_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < OUT_W; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src[0]  <= i_val;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_side[0] <= i_side;
        for (int k = 0; k < OUT_W - 1; k++) begin
            for (int l = 0; l < LANES; l++) begin
                r_src[k+1][l] <= {r_src[k][l][IN_W-3:0], 2'b00};
            end
        end
        for (int k = 0; k < OUT_W; k++) begin
            r_rem[k+1]  <= n_rem[k+1];
            r_root[k+1] <= n_root[k+1];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[OUT_W];
    assign o_root  = r_root[OUT_W];
    assign o_side  = r_side[OUT_W];

endmodule

/* rtl/svaa_div.sv */
// ----------------------------------------------------------------------------
// svaa_div
// Pipelined restoring divider for unit-vector components: each lane forms
// (num * 2^FRAC) / den, one quotient bit per stage. The numerator must not
// exceed the divisor, so the quotient fits in FRAC + 1 bits.
// ----------------------------------------------------------------------------
module svaa_div #(
    parameter int LANES  = 6,
    parameter int DEN_W  = 32,
    parameter int FRAC   = 30,
    parameter int SIDE_W = 1,
    localparam int QW    = FRAC + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [LANES-1:0][DEN_W-1:0]   i_num,
    input  logic [LANES-1:0][DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][QW-1:0]      o_quo,
    output logic [SIDE_W-1:0]             o_side
);

    logic [LANES-1:0][DEN_W-1:0] r_rem  [QW+1];
    logic [LANES-1:0][QW-1:0]    r_low  [QW];
    logic [LANES-1:0][QW-1:0]    r_quo  [QW+1];
    logic [LANES-1:0][DEN_W-1:0] r_den  [QW];
    logic [SIDE_W-1:0]           r_side [QW+1];
    logic                        r_vld  [QW+1];

    logic [LANES-1:0][DEN_W-1:0] n_rem [1:QW];
    logic [LANES-1:0][QW-1:0]    n_quo [1:QW];

    always_comb begin
        logic [DEN_W:0] sh;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < LANES; l++) begin
                sh = {r_rem[k][l], r_low[k][l][QW-1]};
                if (sh >= {1'b0, r_den[k][l]}) begin
                    n_rem[k+1][l] = DEN_W'(sh - {1'b0, r_den[k][l]});
                    n_quo[k+1][l] = {r_quo[k][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[k+1][l] = DEN_W'(sh);
                    n_quo[k+1][l] = {r_quo[k][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < QW; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // The top bits of num * 2^FRAC start as the partial remainder.
        for (int l = 0; l < LANES; l++) begin
            r_rem[0][l] <= {1'b0, i_num[l][DEN_W-1:1]};
            r_low[0][l] <= {i_num[l][0], {FRAC{1'b0}}};
        end
        r_quo[0]  <= '0;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int k = 0; k < QW - 1; k++) begin
            for (int l = 0; l < LANES; l++) begin
                r_low[k+1][l] <= {r_low[k][l][QW-2:0], 1'b0};
            end
            r_den[k+1] <= r_den[k];
        end
        for (int k = 0; k < QW; k++) begin
            r_rem[k+1]  <= n_rem[k+1];
            r_quo[k+1]  <= n_quo[k+1];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_quo[QW];
    assign o_side  = r_side[QW];

endmodule

/* rtl/signed_vector_angle_about_axis_top.sv */
// ----------------------------------------------------------------------------
// signed_vector_angle_about_axis_top
// Angle from vector a to vector b in [0, 360) degrees, turned by the sign of
// the triple product with a reference axis.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start / busy         i_req    (t_req)
//   result    out        o_done strobe        o_result (t_rsp)
//   config    in         i_cfg_we             i_cfg_wdata (cos_tolerance)
//
// One request enters every cycle; busy is always low.
// At most 32 CORDIC iterations are built. The pipeline runs through the
// norm square root, the unit-vector divider, the sine square root and the
// CORDIC chain, each one bit or one step per stage.
// Reset is synchronous; it clears the valid bits and presets the tolerance.
// The result is shown for one cycle and the receiver cannot hold it off.
// ----------------------------------------------------------------------------
module signed_vector_angle_about_axis_top
    import svaa_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_req        i_req,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_done,
    output t_rsp        o_result
);

    localparam int NIT = (CORDIC_ITERATIONS < ATAN_TAB_LEN) ? CORDIC_ITERATIONS
                                                            : ATAN_TAB_LEN;

    typedef struct packed {
        logic               zero;
        logic [5:0]         neg;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
    } t_div_side;

    typedef struct packed {
        logic zero;
        logic near_pos;
        logic near_neg;
        logic tri_neg;
    } t_flags;

    typedef struct packed {
        t_flags             flags;
        logic signed [31:0] c;
    } t_sin_side;

    logic [15:0] r_cos_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_tol <= COS_TOL_RESET;
        end else if (i_cfg_we) begin
            r_cos_tol <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // ---------------- Norms ----------------
    logic        r_s1_vld, r_s2_vld, r_s3_vld;
    t_req        r_s1_req, r_s2_req, r_s3_req;
    logic [63:0] r_s2_sq [6];
    logic [1:0][63:0] r_s3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_req <= i_req;
        r_s2_req <= r_s1_req;
        r_s3_req <= r_s2_req;
        r_s2_sq[0] <= 64'(64'(r_s1_req.a_x) * 64'(r_s1_req.a_x));
        r_s2_sq[1] <= 64'(64'(r_s1_req.a_y) * 64'(r_s1_req.a_y));
        r_s2_sq[2] <= 64'(64'(r_s1_req.a_z) * 64'(r_s1_req.a_z));
        r_s2_sq[3] <= 64'(64'(r_s1_req.b_x) * 64'(r_s1_req.b_x));
        r_s2_sq[4] <= 64'(64'(r_s1_req.b_y) * 64'(r_s1_req.b_y));
        r_s2_sq[5] <= 64'(64'(r_s1_req.b_z) * 64'(r_s1_req.b_z));
        r_s3_sum[0] <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
        r_s3_sum[1] <= r_s2_sq[3] + r_s2_sq[4] + r_s2_sq[5];
    end

    logic             norm_vld;
    logic [1:0][31:0] norm;
    t_req             norm_req;

    svaa_sqrt #(
        .LANES  (2),
        .OUT_W  (32),
        .SIDE_W ($bits(t_req))
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_vld),
        .i_val   (r_s3_sum),
        .i_side  (r_s3_req),
        .o_valid (norm_vld),
        .o_root  (norm),
        .o_side  (norm_req)
    );

    // ---------------- Unit vectors ----------------
    logic signed [31:0] comp [6];
    logic [5:0][31:0]   div_num;
    logic [5:0][31:0]   div_den;
    t_div_side          div_in_side;

    always_comb begin
        comp[0] = norm_req.a_x;
        comp[1] = norm_req.a_y;
        comp[2] = norm_req.a_z;
        comp[3] = norm_req.b_x;
        comp[4] = norm_req.b_y;
        comp[5] = norm_req.b_z;
        for (int l = 0; l < 6; l++) begin
            div_num[l]         = comp[l][31] ? 32'(-comp[l]) : 32'(comp[l]);
            div_den[l]         = (l < 3) ? norm[0] : norm[1];
            div_in_side.neg[l] = comp[l][31];
        end
        div_in_side.zero   = (norm[0] == '0) || (norm[1] == '0);
        div_in_side.axis_x = norm_req.axis_x;
        div_in_side.axis_y = norm_req.axis_y;
        div_in_side.axis_z = norm_req.axis_z;
    end

    logic             quo_vld;
    logic [5:0][30:0] quo;
    t_div_side        quo_side;

    svaa_div #(
        .LANES  (6),
        .DEN_W  (32),
        .FRAC   (30),
        .SIDE_W ($bits(t_div_side))
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_vld),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_side  (div_in_side),
        .o_valid (quo_vld),
        .o_quo   (quo),
        .o_side  (quo_side)
    );

    // ---------------- Dot and cross products ----------------
    logic               r_s5_vld, r_s6_vld, r_s7_vld, r_s8_vld, r_s9_vld, r_s10_vld;
    logic signed [31:0] r_s5_u [3];
    logic signed [31:0] r_s5_v [3];
    t_div_side          r_s5_side, r_s6_side, r_s7_side, r_s8_side;
    logic signed [63:0] r_s6_pd [3];
    logic signed [63:0] r_s6_pc [6];
    logic signed [63:0] r_s7_dot;
    logic signed [63:0] r_s7_w [3];
    logic signed [31:0] r_s8_c;
    logic signed [31:0] r_s8_wt [3];
    logic signed [63:0] r_s9_tp [3];
    logic [60:0]        r_s9_csq;
    logic signed [31:0] r_s9_c;
    t_flags             r_s9_flags;
    logic [61:0]        r_s10_sin_in;
    t_sin_side          r_s10_side;

    logic signed [33:0] dot_shr;
    logic signed [31:0] c_clamp;
    logic [32:0]        dist_pos;
    logic [32:0]        dist_neg;
    logic signed [63:0] tri_sum;

    always_comb begin
        dot_shr = 34'(r_s7_dot >>> 30);
        if (dot_shr > 34'sd1073741824) begin
            c_clamp = $signed(ONE_Q30);
        end else if (dot_shr < -34'sd1073741824) begin
            c_clamp = -$signed(ONE_Q30);
        end else begin
            c_clamp = 32'(dot_shr);
        end
        dist_pos = {1'b0, ONE_Q30} - {r_s8_c[31], r_s8_c};
        dist_neg = {r_s8_c[31], r_s8_c} + {1'b0, ONE_Q30};
        tri_sum  = r_s9_tp[0] + r_s9_tp[1] + r_s9_tp[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
        end else begin
            r_s5_vld  <= quo_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_s5_u[k] <= quo_side.neg[k] ? -$signed({1'b0, quo[k]})
                                         : $signed({1'b0, quo[k]});
            r_s5_v[k] <= quo_side.neg[k+3] ? -$signed({1'b0, quo[k+3]})
                                           : $signed({1'b0, quo[k+3]});
        end
        r_s5_side <= quo_side;

        for (int k = 0; k < 3; k++) begin
            r_s6_pd[k] <= 64'(r_s5_u[k]) * 64'(r_s5_v[k]);
        end
        r_s6_pc[0] <= 64'(r_s5_u[1]) * 64'(r_s5_v[2]);
        r_s6_pc[1] <= 64'(r_s5_u[2]) * 64'(r_s5_v[1]);
        r_s6_pc[2] <= 64'(r_s5_u[2]) * 64'(r_s5_v[0]);
        r_s6_pc[3] <= 64'(r_s5_u[0]) * 64'(r_s5_v[2]);
        r_s6_pc[4] <= 64'(r_s5_u[0]) * 64'(r_s5_v[1]);
        r_s6_pc[5] <= 64'(r_s5_u[1]) * 64'(r_s5_v[0]);
        r_s6_side  <= r_s5_side;

        r_s7_dot  <= r_s6_pd[0] + r_s6_pd[1] + r_s6_pd[2];
        r_s7_w[0] <= r_s6_pc[0] - r_s6_pc[1];
        r_s7_w[1] <= r_s6_pc[2] - r_s6_pc[3];
        r_s7_w[2] <= r_s6_pc[4] - r_s6_pc[5];
        r_s7_side <= r_s6_side;

        r_s8_c <= c_clamp;
        for (int k = 0; k < 3; k++) begin
            r_s8_wt[k] <= 32'(r_s7_w[k] >>> 32);
        end
        r_s8_side <= r_s7_side;

        r_s9_tp[0] <= 64'(r_s8_wt[0]) * 64'(r_s8_side.axis_x);
        r_s9_tp[1] <= 64'(r_s8_wt[1]) * 64'(r_s8_side.axis_y);
        r_s9_tp[2] <= 64'(r_s8_wt[2]) * 64'(r_s8_side.axis_z);
        r_s9_csq   <= 61'(64'(r_s8_c) * 64'(r_s8_c));
        r_s9_c     <= r_s8_c;
        r_s9_flags.zero     <= r_s8_side.zero;
        r_s9_flags.near_pos <= dist_pos <= {17'b0, r_cos_tol};
        r_s9_flags.near_neg <= dist_neg <= {17'b0, r_cos_tol};
        r_s9_flags.tri_neg  <= 1'b0;

        r_s10_sin_in <= 62'(62'h1000_0000_0000_0000 - {1'b0, r_s9_csq});
        r_s10_side.c <= r_s9_c;
        r_s10_side.flags.zero     <= r_s9_flags.zero;
        r_s10_side.flags.near_pos <= r_s9_flags.near_pos;
        r_s10_side.flags.near_neg <= r_s9_flags.near_neg;
        r_s10_side.flags.tri_neg  <= tri_sum[63];
    end

    // ---------------- Sine and CORDIC ----------------
    logic        sin_vld;
    logic [30:0] sin_root;
    t_sin_side   sin_side;

    svaa_sqrt #(
        .LANES  (1),
        .OUT_W  (31),
        .SIDE_W ($bits(t_sin_side))
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s10_vld),
        .i_val   (r_s10_sin_in),
        .i_side  (r_s10_side),
        .o_valid (sin_vld),
        .o_root  (sin_root),
        .o_side  (sin_side)
    );

    logic signed [33:0] r_cx [NIT+1];
    logic signed [33:0] r_cy [NIT+1];
    logic signed [33:0] r_cz [NIT+1];
    t_flags             r_cf [NIT+1];
    logic               r_cv [NIT+1];

    logic signed [33:0] n_cx [1:NIT];
    logic signed [33:0] n_cy [1:NIT];
    logic signed [33:0] n_cz [1:NIT];

    always_comb begin
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [33:0] at;
        for (int i = 0; i < NIT; i++) begin
            xs = r_cx[i] >>> i;
            ys = r_cy[i] >>> i;
            at = $signed({3'b000, atan_deg(i)});
            // Rotate toward the x axis; z gathers the angle turned.
            if (!r_cy[i][33]) begin
                n_cx[i+1] = r_cx[i] + ys;
                n_cy[i+1] = r_cy[i] - xs;
                n_cz[i+1] = r_cz[i] + at;
            end else begin
                n_cx[i+1] = r_cx[i] - ys;
                n_cy[i+1] = r_cy[i] + xs;
                n_cz[i+1] = r_cz[i] - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NIT; i++) begin
                r_cv[i] <= 1'b0;
            end
        end else begin
            r_cv[0] <= sin_vld;
            for (int i = 0; i < NIT; i++) begin
                r_cv[i+1] <= r_cv[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // A negative cosine starts a quarter turn on, with the point rotated.
        if (sin_side.c[31]) begin
            r_cx[0] <= $signed({3'b000, sin_root});
            r_cy[0] <= -34'(sin_side.c);
            r_cz[0] <= $signed({1'b0, DEG90});
        end else begin
            r_cx[0] <= 34'(sin_side.c);
            r_cy[0] <= $signed({3'b000, sin_root});
            r_cz[0] <= '0;
        end
        r_cf[0] <= sin_side.flags;
        for (int i = 0; i < NIT; i++) begin
            r_cx[i+1] <= n_cx[i+1];
            r_cy[i+1] <= n_cy[i+1];
            r_cz[i+1] <= n_cz[i+1];
            r_cf[i+1] <= r_cf[i];
        end
    end

    // ---------------- Final angle ----------------
    logic        r_f1_vld;
    logic [32:0] r_f1_z;
    logic        r_f1_zero;
    logic        r_done;
    t_rsp        r_result;

    logic [32:0] z_clamp;
    logic [32:0] z_sel;
    logic [33:0] z_round;
    logic [25:0] z_out;

    always_comb begin
        if (r_cz[NIT][33]) begin
            z_clamp = '0;
        end else if (r_cz[NIT] > $signed({1'b0, DEG180})) begin
            z_clamp = DEG180;
        end else begin
            z_clamp = 33'(r_cz[NIT]);
        end
        if (r_cf[NIT].near_pos) begin
            z_sel = '0;
        end else if (r_cf[NIT].near_neg) begin
            z_sel = DEG180;
        end else if (r_cf[NIT].tri_neg) begin
            z_sel = DEG360 - z_clamp;
        end else begin
            z_sel = z_clamp;
        end
        z_round = {1'b0, r_f1_z} + 34'd128;
        z_out   = z_round[33:8];
        // A reflected angle that rounds up to a full turn wraps to zero.
        if (z_out >= OUT_DEG360) begin
            z_out = z_out - OUT_DEG360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_f1_vld <= r_cv[NIT];
            r_done   <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_z    <= z_sel;
        r_f1_zero <= r_cf[NIT].zero;
        r_result.angle_deg <= r_f1_zero ? '0 : 25'(z_out);
        r_result.status    <= r_f1_zero;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/svaa_checker.sv */
// ----------------------------------------------------------------------------
// svaa_checker
// Port-level checks on the vector angle block, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_vector_angle_about_axis_top_assert.svh"

module svaa_checker
    import svaa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_result
);

    // A request is never refused.
    `SVAA_ASSERT_IMP(a_start_taken, start, !busy, "request refused by busy")

    // A zero-length vector reports a zero angle.
    `SVAA_ASSERT_IMP(a_status_zero, o_done && o_result.status, o_result.angle_deg == '0, "flagged result carries nonzero angle")

    // Reported angles stay below a full turn.
    `SVAA_ASSERT_IMP(a_angle_range, o_done, {1'b0, o_result.angle_deg} < OUT_DEG360, "angle reaches 360 degrees")

    // The pipeline is empty when reset is released and for the cycle after.
    `SVAA_ASSERT_IMP(a_reset_empty, $rose(i_rst_n), !o_done, "result right after reset")
    `SVAA_ASSERT_NXT(a_reset_empty_next, $rose(i_rst_n), !o_done, "result one cycle after reset")

endmodule

bind signed_vector_angle_about_axis_top svaa_checker u_svaa_checker (.*);
